// ----- design/pidc_pkg.sv -----
// pidc_pkg: shared types, widths and reset constants for the PID controller core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pidc_pkg;

  localparam int unsigned DataW  = 32;   // Q16.16 samples
  localparam int unsigned GainW  = 16;   // Q8.8 gains
  localparam int unsigned LimW   = 31;   // unsigned magnitudes
  localparam int unsigned CfgIdxW = 3;

  localparam logic [LimW-1:0] WindupLimitRst = 31'd32768000;  // 500.0
  localparam logic [LimW-1:0] DriveLimitRst  = 31'd65536000;  // 1000.0

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_I       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_DEAD_BAND    = 3'd3,
    REG_WINDUP_LIMIT = 3'd4,
    REG_DRIVE_LIMIT  = 3'd5
  } pidc_reg_e;

  // Result of the error/integral stage
  typedef struct packed {
    logic signed [DataW-1:0] err;       // post dead zone error
    logic signed [DataW-1:0] acc_next;  // updated integral
    logic signed [DataW:0]   deriv;     // exact 33-bit derivative
  } pidc_err_t;

endpackage : pidc_pkg

`default_nettype wire

// ----- design/pidc_err_unit.sv -----
// pidc_err_unit: saturated error, dead zone, gated and clamped integral, derivative.
// Combinational; depends on pidc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pidc_err_unit (
  input  wire logic signed [pidc_pkg::DataW-1:0] target_i,
  input  wire logic signed [pidc_pkg::DataW-1:0] sensed_i,
  input  wire logic signed [pidc_pkg::DataW-1:0] acc_i,
  input  wire logic signed [pidc_pkg::DataW-1:0] last_i,
  input  wire logic        [pidc_pkg::LimW-1:0]  dead_band_i,
  input  wire logic        [pidc_pkg::LimW-1:0]  windup_limit_i,
  output pidc_pkg::pidc_err_t                    res_o
);
  import pidc_pkg::*;

  logic signed [DataW:0]   diff;
  logic signed [DataW-1:0] err_sat;
  logic        [DataW-1:0] mag_sat;
  logic signed [DataW-1:0] err;
  logic        [DataW-1:0] mag;
  logic signed [DataW:0]   acc_sum;
  logic signed [DataW:0]   lim;
  logic signed [DataW-1:0] acc_clamped;

  always_comb begin
    diff = {target_i[DataW-1], target_i} - {sensed_i[DataW-1], sensed_i};
    // saturate to 32 bits
    if (diff[DataW] != diff[DataW-1]) begin
      err_sat = diff[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      err_sat = diff[DataW-1:0];
    end
    // magnitude; most negative value maps to 2^31 as unsigned
    mag_sat = err_sat[DataW-1] ? DataW'(-err_sat) : err_sat;

    // dead zone (strict compare)
    if (mag_sat < {1'b0, dead_band_i}) begin
      err = '0;
      mag = '0;
    end else begin
      err = err_sat;
      mag = mag_sat;
    end

    acc_sum = {acc_i[DataW-1], acc_i} + {err[DataW-1], err};
    lim     = $signed({2'b00, windup_limit_i});
    if (acc_sum > lim) begin
      acc_clamped = lim[DataW-1:0];
    end else if (acc_sum < -lim) begin
      acc_clamped = DataW'(-lim);
    end else begin
      acc_clamped = acc_sum[DataW-1:0];
    end

    // integrate only inside the gate; otherwise hold
    res_o.acc_next = (mag < {1'b0, windup_limit_i}) ? acc_clamped : acc_i;
    res_o.err      = err;
    res_o.deriv    = {err[DataW-1], err} - {last_i[DataW-1], last_i};
  end

endmodule : pidc_err_unit

`default_nettype wire

// ----- design/pid_controller_deadzone_clamped_core.sv -----
// pid_controller_deadzone_clamped_core: top level of the fixed-point PID controller.
// Depends on pidc_pkg and pidc_err_unit.
`timescale 1ns / 1ps
`default_nettype none

// Fixed-point PID controller with dead zone, conditional integration and output
// clamp. Each request carries target and sensed (Q16.16) in tdata and a command bit
// in tuser; command 1 clears the integral and previous error and returns nothing,
// command 0 returns one drive value (Q16.16). Throughput is one request per clock
// while the output is not stalled; a request passes the input register, then the
// error, product and output registers. The integral and previous-error registers
// are updated in the first stage (error/dead zone/integral logic), which is the
// feedback loop that sets the rate; stage two forms the three gain products, stage
// three sums, shifts right 8 (rounding toward minus infinity) and clamps. Each
// stage holds while the one after it is full and stalled, so a waiting result
// does not block input until the pipeline is full. Configuration writes are taken
// any cycle but should only happen when the pipeline is empty.
module pid_controller_deadzone_clamped_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration
  input  wire logic                            cfg_we_i,
  input  wire logic [pidc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [pidc_pkg::LimW-1:0]       cfg_data_i,
  // input stream
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  wire logic [2*pidc_pkg::DataW-1:0]    s_axis_tdata_i,   // [31:0] target, [63:32] sensed
  input  wire logic                            s_axis_tuser_i,   // [0] command
  // output stream
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output logic [pidc_pkg::DataW-1:0]           m_axis_tdata_o    // [31:0] drive
);
  import pidc_pkg::*;

  localparam int unsigned ProdPW = DataW + GainW;       // 48
  localparam int unsigned ProdDW = DataW + 1 + GainW;   // 49
  localparam int unsigned SumW   = ProdDW + 2;          // 51
  localparam int unsigned ShW    = SumW - 8;            // 43

  // configuration registers
  logic signed [GainW-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic        [LimW-1:0]  dead_band_q, windup_limit_q, drive_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q       <= '0;
      gain_i_q       <= '0;
      gain_d_q       <= '0;
      dead_band_q    <= '0;
      windup_limit_q <= WindupLimitRst;
      drive_limit_q  <= DriveLimitRst;
    end else if (cfg_we_i) begin
      unique case (pidc_reg_e'(cfg_idx_i))
        REG_GAIN_P:       gain_p_q       <= cfg_data_i[GainW-1:0];
        REG_GAIN_I:       gain_i_q       <= cfg_data_i[GainW-1:0];
        REG_GAIN_D:       gain_d_q       <= cfg_data_i[GainW-1:0];
        REG_DEAD_BAND:    dead_band_q    <= cfg_data_i;
        REG_WINDUP_LIMIT: windup_limit_q <= cfg_data_i;
        REG_DRIVE_LIMIT:  drive_limit_q  <= cfg_data_i;
        default: ;  // unmapped index, write ignored
      endcase
    end
  end

  // pipeline valids and per-stage ready
  logic v0_q, v1_q, v2_q, v3_q;
  logic rdy0, rdy1, rdy2, rdy3;

  assign rdy3 = !v3_q || m_axis_tready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;
  assign s_axis_tready_o = rdy0;

  // stage 0: input register
  logic                    cmd0_q;
  logic signed [DataW-1:0] target0_q, sensed0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (rdy0) begin
      v0_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && s_axis_tvalid_i) begin
      cmd0_q    <= s_axis_tuser_i;
      target0_q <= s_axis_tdata_i[DataW-1:0];
      sensed0_q <= s_axis_tdata_i[2*DataW-1:DataW];
    end
  end

  // stage 1: error, integral, derivative; controller state lives here
  logic signed [DataW-1:0] acc_q, last_q;
  pidc_err_t               eu;
  logic                    adv0;

  assign adv0 = v0_q && rdy1;

  pidc_err_unit u_err (
    .target_i       (target0_q),
    .sensed_i       (sensed0_q),
    .acc_i          (acc_q),
    .last_i         (last_q),
    .dead_band_i    (dead_band_q),
    .windup_limit_i (windup_limit_q),
    .res_o          (eu)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      last_q <= '0;
    end else if (adv0) begin
      if (cmd0_q) begin
        acc_q  <= '0;
        last_q <= '0;
      end else begin
        acc_q  <= eu.acc_next;
        last_q <= eu.err;
      end
    end
  end

  logic signed [DataW-1:0] err1_q, acc1_q;
  logic signed [DataW:0]   deriv1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= v0_q && !cmd0_q;  // clear produces no result
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv0 && !cmd0_q) begin
      err1_q   <= eu.err;
      acc1_q   <= eu.acc_next;
      deriv1_q <= eu.deriv;
    end
  end

  // stage 2: gain products
  logic signed [ProdPW-1:0] prod_p_q, prod_i_q;
  logic signed [ProdDW-1:0] prod_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) begin
      prod_p_q <= gain_p_q * err1_q;
      prod_i_q <= gain_i_q * acc1_q;
      prod_d_q <= gain_d_q * deriv1_q;
    end
  end

  // stage 3: sum, floor shift, clamp, output register
  logic signed [SumW-1:0]  sum_d;
  logic signed [ShW-1:0]   sh_d;
  logic signed [ShW-1:0]   dlim;
  logic signed [DataW-1:0] drive_d, drive_q;

  always_comb begin
    sum_d = SumW'(prod_p_q) + SumW'(prod_i_q) + SumW'(prod_d_q);
    sh_d  = sum_d[SumW-1:8];  // arithmetic shift, floor
    dlim  = $signed({{(ShW-LimW){1'b0}}, drive_limit_q});
    if (sh_d > dlim) begin
      drive_d = dlim[DataW-1:0];
    end else if (sh_d < -dlim) begin
      drive_d = DataW'(-dlim);
    end else begin
      drive_d = sh_d[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && rdy3) begin
      drive_q <= drive_d;
    end
  end

  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = drive_q;

  // assertions
  a_clear_zeroes_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv0 && cmd0_q |=> acc_q == '0 && last_q == '0)
    else $error("clear did not zero controller state");

  a_clear_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv0 && cmd0_q |=> !v1_q)
    else $error("clear request produced a result");

  a_stage2_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && rdy3 |=> v3_q)
    else $error("product stage advanced but output empty");

endmodule : pid_controller_deadzone_clamped_core

`default_nettype wire
